// ----- src/lbv_pkg.sv -----
// ----------------------------------------------------------------------------
// lbv_pkg: shared types and constants of the learning bridge
// table sizes, tag codes, register indexes, controller states and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package lbv_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int MAX_PORTS   = 16;

  localparam logic [15:0] VLAN_TYPE = 16'h8100;
  localparam logic [47:0] BCAST_MAC = {6{8'hff}};

  localparam logic [3:0] REG_PORT_COUNT  = 4'd0;
  localparam logic [3:0] REG_UPLINK_PORT = 4'd1;
  localparam logic [3:0] REG_TAG_ENABLE  = 4'd2;
  localparam logic [3:0] REG_VLAN_IDENT  = 4'd3;

  typedef enum logic [1:0] {
    TAG_NONE   = 2'd0,
    TAG_INSERT = 2'd1,
    TAG_STRIP  = 2'd2
  } tag_act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SEND,
    ST_FLOOD
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  ingress_port;
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [15:0] tag_word;
    logic        length_ok;
  } in_item_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic decide;
    logic flood_adv;
    logic sel_flood;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic do_one;
    logic do_flood;
    logic flood_last;
  } status_t;

endpackage

// ----- src/lbv_ifs.sv -----
// ----------------------------------------------------------------------------
// lbv channel interfaces
// valid/ready channels for frame headers, forwarding results and config
// ----------------------------------------------------------------------------
interface lbv_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  ingress_port;
  logic [47:0] dest_mac;
  logic [47:0] src_mac;
  logic [15:0] ether_type;
  logic [15:0] tag_word;
  logic        length_ok;
  modport source (output valid, kind, ingress_port, dest_mac, src_mac, ether_type,
                  tag_word, length_ok, input ready);
  modport sink (input valid, kind, ingress_port, dest_mac, src_mac, ether_type,
                tag_word, length_ok, output ready);
endinterface

interface lbv_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] egress_port;
  logic [1:0] tag_action;
  logic       last;
  modport source (output valid, egress_port, tag_action, last, input ready);
  modport sink (input valid, egress_port, tag_action, last, output ready);
endinterface

interface lbv_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/learning_bridge_vlan_forwarder_unit.sv -----
// ----------------------------------------------------------------------------
// learning_bridge_vlan_forwarder_unit: learning bridge with vlan tagging
// one frame header per item, forwarding results with port and tag action
// an item is accepted, the table is scanned one entry a cycle, then a decision
// is made before the first result; the next item is accepted only after the
// last result of the current one has been taken
// reset: synchronous active low, empties the table and loads config defaults
// ----------------------------------------------------------------------------
module learning_bridge_vlan_forwarder_unit
  import lbv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lbv_in_if.sink    in_ch,
  lbv_out_if.source out_ch,
  lbv_cfg_if.sink   cfg_ch
);

  cmd_t     cmd;
  status_t  sts;
  in_item_t in_item;

  // the user must issue config writes only while idle; the block does not enforce it and always takes them
  assign cfg_ch.ready = 1'b1;

  // pack the header into one item
  assign in_item = '{kind: in_ch.kind, ingress_port: in_ch.ingress_port,
                     dest_mac: in_ch.dest_mac, src_mac: in_ch.src_mac,
                     ether_type: in_ch.ether_type, tag_word: in_ch.tag_word,
                     length_ok: in_ch.length_ok};

  // controller: accept, scan, decide, deliver
  lbv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: table, match flags, decision and result payload
  lbv_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .cmd         (cmd),
    .sts         (sts),
    .egress_port (out_ch.egress_port),
    .tag_action  (out_ch.tag_action),
    .last        (out_ch.last)
  );

endmodule

// ----- src/lbv_ctrl.sv -----
// ----------------------------------------------------------------------------
// lbv_ctrl: controller state machine
// sequences accept, table scan, decision and result delivery
// ----------------------------------------------------------------------------
module lbv_ctrl
  import lbv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (sts.scan_done) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (sts.do_one) state_nxt = ST_SEND;
        else if (sts.do_flood) state_nxt = ST_FLOOD;
        else state_nxt = ST_IDLE;
      end
      ST_SEND:   if (out_ready) state_nxt = ST_IDLE;
      ST_FLOOD:  if (out_ready && sts.flood_last) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN:   cmd.scan_en = 1'b1;
      ST_DECIDE: cmd.decide = 1'b1;
      ST_SEND:   out_valid = 1'b1;
      ST_FLOOD: begin
        out_valid     = 1'b1;
        cmd.sel_flood = 1'b1;
        cmd.flood_adv = out_ready;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- src/lbv_datapath.sv -----
// ----------------------------------------------------------------------------
// lbv_datapath: header registers, address table and forwarding decision
// holds config, scans the table one entry a cycle, writes learned and updated entries
// ----------------------------------------------------------------------------
module lbv_datapath
  import lbv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_item,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  cmd_t        cmd,
  output status_t     sts,
  output logic [3:0]  egress_port,
  output logic [1:0]  tag_action,
  output logic        last
);

  // config
  logic [4:0]  port_count_r;
  logic [3:0]  uplink_r;
  logic        tag_en_r;
  logic [11:0] vid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_count_r <= 5'd3;
      uplink_r     <= 4'd2;
      tag_en_r     <= 1'b1;
      vid_r        <= 12'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PORT_COUNT:  port_count_r <= cfg_data[4:0];
        REG_UPLINK_PORT: uplink_r     <= cfg_data[3:0];
        REG_TAG_ENABLE:  tag_en_r     <= cfg_data[0];
        REG_VLAN_IDENT:  vid_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  in_item_t item_r;
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
  end

  // table memories, filled in order so the fill count marks valid entries
  logic [47:0] mac_mem [TABLE_DEPTH];
  logic [3:0]  port_mem [TABLE_DEPTH];
  logic [47:0] rd_mac_r;
  logic [3:0]  rd_port_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] ptr_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_vld_r;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic             wr_mac;
  logic [3:0]       wport;

  logic issue;
  assign issue = cmd.scan_en && (ptr_r < count_r);

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_mac_r  <= mac_mem[ptr_r[IDX_W-1:0]];
      rd_port_r <= port_mem[ptr_r[IDX_W-1:0]];
      rd_idx_r  <= ptr_r[IDX_W-1:0];
    end
    if (we) begin
      port_mem[waddr] <= wport;
      if (wr_mac) mac_mem[waddr] <= item_r.src_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
    end else if (cmd.load) begin
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (issue) ptr_r <= ptr_r + 1'b1;
    end
  end

  // match flags
  logic             s_found_r, d_found_r;
  logic [IDX_W-1:0] s_idx_r;
  logic [3:0]       s_port_r, d_port_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_found_r <= 1'b0;
      d_found_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (!s_found_r && rd_mac_r == item_r.src_mac) begin
        s_found_r <= 1'b1;
        s_idx_r   <= rd_idx_r;
        s_port_r  <= rd_port_r;
      end
      if (!d_found_r && rd_mac_r == item_r.dest_mac) begin
        d_found_r <= 1'b1;
        d_port_r  <= rd_port_r;
      end
    end
  end

  assign sts.scan_done = (ptr_r == count_r) && !rd_vld_r;

  // decision
  logic       bcast, one, fl, upd, lrn;
  logic [3:0] one_port, lrn_port;
  tag_act_t   act;

  always_comb begin
    bcast    = (item_r.dest_mac == BCAST_MAC);
    one      = 1'b0;
    fl       = 1'b0;
    upd      = 1'b0;
    lrn      = 1'b0;
    one_port = uplink_r;
    lrn_port = uplink_r;
    if (item_r.kind == 1'b0) begin
      act = (tag_en_r && vid_r != 12'd1) ? TAG_INSERT : TAG_NONE;
      if (s_found_r) begin
        if (s_port_r == uplink_r) begin
          one = 1'b0;
        end else if (s_port_r != item_r.ingress_port) begin
          upd = 1'b1;
        end else begin
          one = 1'b1;
        end
      end else begin
        one      = bcast;
        lrn      = 1'b1;
        lrn_port = item_r.ingress_port;
      end
    end else begin
      act = (item_r.ether_type == VLAN_TYPE && item_r.tag_word == {4'd0, vid_r})
            ? TAG_STRIP : TAG_NONE;
      if (s_found_r) begin
        if (s_port_r == uplink_r) begin
          if (d_found_r) begin
            one      = (d_port_r != uplink_r);
            one_port = d_port_r;
          end else begin
            fl = bcast;
          end
        end
      end else begin
        lrn = 1'b1;
        fl  = bcast;
      end
    end
    if (!item_r.length_ok) begin
      one = 1'b0;
      fl  = 1'b0;
      upd = 1'b0;
      lrn = 1'b0;
    end
  end

  // flood walk over ports 1 .. lim-1 skipping the uplink
  logic [4:0] lim, first, fl_r, fl_next;
  always_comb begin
    lim = (port_count_r > 5'(MAX_PORTS)) ? 5'(MAX_PORTS) : port_count_r;
    if (lim > 5'd16) lim = 5'd16;
    first   = ({1'b0, uplink_r} == 5'd1) ? 5'd2 : 5'd1;
    fl_next = fl_r + 5'd1;
    if (fl_next == {1'b0, uplink_r}) fl_next = fl_r + 5'd2;
  end

  assign sts.do_one     = one;
  assign sts.do_flood   = fl && (first < lim);
  assign sts.flood_last = (fl_next >= lim);

  assign we     = cmd.decide && (upd || (lrn && count_r < CNT_W'(TABLE_DEPTH)));
  assign wr_mac = !upd;
  assign waddr  = upd ? s_idx_r : count_r[IDX_W-1:0];
  assign wport  = upd ? item_r.ingress_port : lrn_port;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.decide && lrn && count_r < CNT_W'(TABLE_DEPTH)) begin
      count_r <= count_r + 1'b1;
    end
  end

  logic [3:0] one_port_r;
  logic [1:0] act_r;
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      one_port_r <= one_port;
      act_r      <= act;
      fl_r       <= first;
    end else if (cmd.flood_adv) begin
      fl_r <= fl_next;
    end
  end

  assign egress_port = cmd.sel_flood ? fl_r[3:0] : one_port_r;
  assign tag_action  = act_r;
  assign last        = cmd.sel_flood ? sts.flood_last : 1'b1;

endmodule

// ----- src/lbv_checker.sv -----
// ----------------------------------------------------------------------------
// lbv_checker: port-level checks of the learning bridge
// handshake hold and one-item-at-a-time sequencing
// ----------------------------------------------------------------------------
module lbv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] egress_port,
  input logic       last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(egress_port) && $stable(last))
    else $error("stalled result changed");

  // no new item while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("item accepted while result pending");

  // after an accept the block is busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // the final result ends the item
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last |=> !out_valid)
    else $error("result after last");

endmodule

bind learning_bridge_vlan_forwarder_unit lbv_checker u_lbv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .egress_port (out_ch.egress_port),
  .last        (out_ch.last)
);
